// ===== rtl/core/kfi_pkg.sv =====
// Keyframe interpolator package: shared types, constants and state codes.
// No dependencies.
package kfi_pkg;

  localparam int MAX_KEYS_DEF = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NEG_TIME  = 2'd2,
    ST_RESERVED  = 2'd3
  } status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] item_time;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               out_of_range;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_LAST_RD,
    S_LAST,
    S_LEFT_RD,
    S_LEFT,
    S_MUL,
    S_PROD,
    S_DIV,
    S_DONE
  } fsm_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

// ===== rtl/core/keyframe_interpolator.sv =====
// Keyframe interpolator top level: keyframe memories, control sequencer. Uses kfi_pkg, kfi_div.
// Paths: reject or trivial sample; last value; insert at the end or mid-table (later keys shifted up);
//   interpolation scans to the first later key, then multiplies and divides.
// Throughput: one word at a time, busy high from acceptance until the result word shows.
// Reset: synchronous; clears key count, start value, sequencer; memories undefined.
// The receiver cannot stall: each result word is shown for one cycle on done.
module keyframe_interpolator #(
  parameter int MAX_KEYS = kfi_pkg::MAX_KEYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  kfi_pkg::in_word_t    in_word,
  output logic                 done,
  output kfi_pkg::out_word_t   out_word,
  input  logic                 cfg_we,
  input  logic signed [31:0]   cfg_data
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  // keyframe memories, one read and one write port each, registered read
  logic signed [31:0] mem_t [MAX_KEYS];
  logic signed [31:0] mem_v [MAX_KEYS];
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_t, wr_v, rd_t, rd_v;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_t[wr_addr] <= wr_t;
      mem_v[wr_addr] <= wr_v;
    end
    rd_t <= mem_t[rd_addr];
    rd_v <= mem_v[rd_addr];
  end

  kfi_pkg::fsm_t      state, state_next;
  logic [CW-1:0]      key_count;
  logic signed [31:0] origin_value; // value ahead of the first key
  kfi_pkg::in_word_t  item;
  logic [CW-1:0]      idx;          // scan / shift index
  logic [CW-1:0]      pos;          // insert slot found by the scan
  logic signed [31:0] last_t;       // time of last key, for range flag
  logic signed [31:0] rt, rv, lt, lv;
  logic signed [32:0] dv;
  logic               neg_diff;
  logic [31:0]        mag, num;
  logic [32:0]        den;
  logic [63:0]        prod;
  kfi_pkg::div_ctl_t  dctl;
  logic [31:0]        quo;
  logic               ddone;

  kfi_div u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .num(prod), .den(den), .quo(quo), .done(ddone)
  );

  assign busy = (state != kfi_pkg::S_IDLE);

  // value step between the bracketing keys; sign kept apart, magnitude fits 32 bits
  assign dv       = 33'(rv) - 33'(lv);
  assign neg_diff = dv[32];
  // operands registered in S_MUL; product taken by the divider on its start edge
  assign prod     = 64'(mag) * 64'(num);

  // empty table / negative time / beyond last key
  function automatic logic outside(input logic signed [31:0] t,
                                   input logic [CW-1:0] cnt,
                                   input logic signed [31:0] lst);
    outside = (t < 0) || (cnt == '0) || (t > lst);
  endfunction

  // Sequencer: next state and memory / divider strobes
  always_comb begin
    state_next = state;
    rd_addr    = idx[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx[AW-1:0];
    wr_t       = rd_t;
    wr_v       = rd_v;
    dctl.start = 1'b0;
    case (state)
      kfi_pkg::S_IDLE: begin
        if (start) begin
          if (in_word.cmd == kfi_pkg::CMD_INSERT) begin
            if (in_word.item_time < 0) state_next = kfi_pkg::S_DONE;
            else if (key_count == CW'(MAX_KEYS)) state_next = kfi_pkg::S_DONE;
            else if (key_count == '0) state_next = kfi_pkg::S_PLACE;
            else state_next = kfi_pkg::S_SCAN_RD;
          end else if (key_count == '0 || in_word.item_time < 0) begin
            state_next = kfi_pkg::S_DONE;
          end else if (in_word.item_time >= last_t) begin
            // no later key: last value, no scan needed
            state_next = kfi_pkg::S_LAST_RD;
          end else begin
            state_next = kfi_pkg::S_SCAN_RD;
          end
        end
      end
      kfi_pkg::S_SCAN_RD: state_next = kfi_pkg::S_SCAN;
      kfi_pkg::S_SCAN: begin
        if (rd_t > item.item_time) begin
          if (item.cmd == kfi_pkg::CMD_INSERT) state_next = kfi_pkg::S_SHIFT_RD;
          else if (idx == '0) state_next = kfi_pkg::S_MUL;
          else state_next = kfi_pkg::S_LEFT_RD;
        end else if (idx + CW'(1) == key_count) begin
          // insert at the end (samples past the end never scan)
          state_next = kfi_pkg::S_PLACE;
        end else begin
          state_next = kfi_pkg::S_SCAN_RD;
        end
      end
      kfi_pkg::S_SHIFT_RD: begin
        rd_addr    = AW'(idx - CW'(1));
        state_next = kfi_pkg::S_SHIFT_WR;
      end
      kfi_pkg::S_SHIFT_WR: begin
        wr_en = 1'b1;
        if (idx - CW'(1) == pos) state_next = kfi_pkg::S_PLACE;
        else state_next = kfi_pkg::S_SHIFT_RD;
      end
      kfi_pkg::S_PLACE: begin
        wr_en      = 1'b1;
        wr_t       = item.item_time;
        wr_v       = item.item_value;
        state_next = kfi_pkg::S_DONE;
      end
      kfi_pkg::S_LAST_RD: begin
        rd_addr    = AW'(key_count - CW'(1));
        state_next = kfi_pkg::S_LAST;
      end
      kfi_pkg::S_LAST: state_next = kfi_pkg::S_DONE;
      kfi_pkg::S_LEFT_RD: begin
        rd_addr    = AW'(idx - CW'(1));
        state_next = kfi_pkg::S_LEFT;
      end
      kfi_pkg::S_LEFT: state_next = kfi_pkg::S_MUL;
      kfi_pkg::S_MUL: state_next = kfi_pkg::S_PROD;
      kfi_pkg::S_PROD: begin
        dctl.start = 1'b1;
        state_next = kfi_pkg::S_DIV;
      end
      kfi_pkg::S_DIV: begin
        if (ddone) state_next = kfi_pkg::S_DONE;
      end
      kfi_pkg::S_DONE: state_next = kfi_pkg::S_IDLE;
      default: state_next = kfi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kfi_pkg::S_IDLE;
      key_count    <= '0;
      origin_value <= '0;
      last_t       <= '0;
      done         <= 1'b0;
    end else begin
      done  <= 1'b0;
      state <= state_next;
      if (cfg_we) origin_value <= cfg_data;
      case (state)
        kfi_pkg::S_IDLE: begin
          if (start) begin
            item <= in_word;
            idx  <= '0;
            if (in_word.cmd == kfi_pkg::CMD_INSERT) begin
              out_word.result_value <= '0;
              if (in_word.item_time < 0) begin
                out_word.status       <= kfi_pkg::ST_NEG_TIME;
                out_word.out_of_range <= 1'b1;
              end else if (key_count == CW'(MAX_KEYS)) begin
                out_word.status       <= kfi_pkg::ST_FULL;
                out_word.out_of_range <= outside(in_word.item_time, key_count, last_t);
              end else begin
                // range flag settles once the key is placed
                out_word.status <= kfi_pkg::ST_OK;
              end
            end else begin
              // start value stands unless a later step replaces it
              out_word.result_value <= origin_value;
              out_word.status       <= kfi_pkg::ST_OK;
              out_word.out_of_range <= outside(in_word.item_time, key_count, last_t);
            end
          end
        end
        kfi_pkg::S_SCAN: begin
          if (rd_t > item.item_time) begin
            if (item.cmd == kfi_pkg::CMD_INSERT) begin
              pos <= idx;
              idx <= key_count;
            end else begin
              rt <= rd_t;
              rv <= rd_v;
              if (idx == '0) begin
                // ahead of the first key: ramp from the start value at time 0
                lt <= '0;
                lv <= origin_value;
              end
            end
          end else if (idx + CW'(1) == key_count) begin
            idx <= key_count;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        kfi_pkg::S_SHIFT_WR: idx <= idx - CW'(1);
        kfi_pkg::S_PLACE: begin
          key_count <= key_count + CW'(1);
          if (idx == key_count) last_t <= item.item_time;
          out_word.out_of_range <= outside(item.item_time, CW'(key_count + CW'(1)),
                                   (idx == key_count) ? item.item_time : last_t);
        end
        kfi_pkg::S_LAST: out_word.result_value <= rd_v;
        kfi_pkg::S_LEFT: begin
          lt <= rd_t;
          lv <= rd_v;
        end
        kfi_pkg::S_MUL: begin
          // time offset and span are non-negative and below 2^31
          mag <= neg_diff ? 32'(-dv) : dv[31:0];
          num <= item.item_time - lt;
          den <= {1'b0, rt - lt};
        end
        kfi_pkg::S_DIV: begin
          if (ddone)
            out_word.result_value <= neg_diff ? lv - quo : lv + quo;
        end
        kfi_pkg::S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !$past(done));
  assert property (@(posedge clk) disable iff (rst) key_count <= CW'(MAX_KEYS))
    else $error("key count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");

endmodule

// ===== rtl/core/kfi_div.sv =====
// Keyframe interpolator divider: restoring unsigned 64 / 33 bit division,
// one quotient bit per cycle, low 32 quotient bits out. Depends on kfi_pkg.
module kfi_div (
  input  logic        clk,
  input  logic        rst,
  input  kfi_pkg::div_ctl_t ctl,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic [31:0] quo,
  output logic        done
);

  logic [63:0] q;
  logic [32:0] rem;
  logic [6:0]  cnt;
  logic        run;
  logic [33:0] trial;

  // den must stay steady for the whole run
  assign trial = {rem, q[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= 7'd0;
        q   <= num;
        rem <= '0;
      end else if (run) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient of an interpolation step always fits in 32 bits
  assign quo = q[31:0];

endmodule
